// ===== sv/scale_pitch_quantizer_defines.svh =====
// assertion helpers used by the quantiser top level
`ifndef SCALE_PITCH_QUANTIZER_DEFINES_SVH
`define SCALE_PITCH_QUANTIZER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SPQ_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("quantiser check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("quantiser check failed");

`endif

// ===== sv/spq_pkg.sv =====
package spq_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int VOLT_W     = 20;
	localparam int OCT_W      = VOLT_W - FRAC_BITS;
	localparam int SEMI_W     = 8;
	localparam int NOTE_W     = 4;
	localparam int MAX_NOTES  = 13;
	localparam int LEAVES     = 16;
	localparam int DIST_W     = FRAC_BITS + NOTE_W;
	localparam int KEY_W      = 5;
	localparam int NV_ENTRIES = 2 ** KEY_W;
	localparam int NV_W       = FRAC_BITS + 2;
	localparam int ONE        = 2 ** FRAC_BITS;

	// register indexes
	localparam logic [1:0] REG_ROOT   = 2'd0;
	localparam logic [1:0] REG_SCALE  = 2'd1;
	localparam logic [1:0] REG_SPARSE = 2'd2;

	// scale codes
	localparam logic [4:0] SC_AEOLIAN    = 5'd0;
	localparam logic [4:0] SC_BLUES      = 5'd1;
	localparam logic [4:0] SC_CHROMATIC  = 5'd2;
	localparam logic [4:0] SC_DIA_MINOR  = 5'd3;
	localparam logic [4:0] SC_DORIAN     = 5'd4;
	localparam logic [4:0] SC_HARM_MINOR = 5'd5;
	localparam logic [4:0] SC_INDIAN     = 5'd6;
	localparam logic [4:0] SC_LOCRIAN    = 5'd7;
	localparam logic [4:0] SC_LYDIAN     = 5'd8;
	localparam logic [4:0] SC_MAJOR      = 5'd9;
	localparam logic [4:0] SC_MEL_MINOR  = 5'd10;
	localparam logic [4:0] SC_MINOR      = 5'd11;
	localparam logic [4:0] SC_MIXOLYDIAN = 5'd12;
	localparam logic [4:0] SC_NAT_MINOR  = 5'd13;
	localparam logic [4:0] SC_PENTATONIC = 5'd14;
	localparam logic [4:0] SC_PHRYGIAN   = 5'd15;
	localparam logic [4:0] SC_TURKISH    = 5'd16;
	localparam logic [4:0] SC_NONE       = 5'd17;

	// sparsity codes
	localparam logic [2:0] SP_FULL      = 3'd0;
	localparam logic [2:0] SP_TRIAD     = 3'd1;
	localparam logic [2:0] SP_THIRD     = 3'd2;
	localparam logic [2:0] SP_FIFTH     = 3'd3;
	localparam logic [2:0] SP_ROOT_ONLY = 3'd4;

	localparam logic [3:0] RST_ROOT   = 4'd0;
	localparam logic [4:0] RST_SCALE  = SC_CHROMATIC;
	localparam logic [2:0] RST_SPARSE = SP_FULL;

	typedef logic [0:MAX_NOTES-1][NOTE_W-1:0] row_t;

	typedef struct packed {
		logic [3:0] root_note;
		logic [4:0] scale_select;
		logic [2:0] sparsity;
	} cfg_t;

	typedef struct packed {
		logic signed [VOLT_W-1:0] volts_out;
		logic signed [SEMI_W-1:0] semitone;
		logic                     passed_through;
	} res_t;

	function automatic row_t scale_row(input logic [4:0] sc);
		row_t r;
		case (sc)
			SC_AEOLIAN, SC_DIA_MINOR, SC_MINOR, SC_NAT_MINOR:
				r = '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12,
					4'd0, 4'd0, 4'd0, 4'd0, 4'd0};
			SC_BLUES:
				r = '{4'd0, 4'd3, 4'd5, 4'd6, 4'd7, 4'd10, 4'd12, 4'd0,
					4'd0, 4'd0, 4'd0, 4'd0, 4'd0};
			SC_CHROMATIC:
				r = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
					4'd8, 4'd9, 4'd10, 4'd11, 4'd12};
			SC_DORIAN:
				r = '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9, 4'd10, 4'd12,
					4'd0, 4'd0, 4'd0, 4'd0, 4'd0};
			SC_HARM_MINOR:
				r = '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd11, 4'd12,
					4'd0, 4'd0, 4'd0, 4'd0, 4'd0};
			SC_INDIAN:
				r = '{4'd0, 4'd1, 4'd1, 4'd4, 4'd5, 4'd8, 4'd10, 4'd12,
					4'd0, 4'd0, 4'd0, 4'd0, 4'd0};
			SC_LOCRIAN:
				r = '{4'd0, 4'd1, 4'd3, 4'd5, 4'd6, 4'd8, 4'd10, 4'd12,
					4'd0, 4'd0, 4'd0, 4'd0, 4'd0};
			SC_LYDIAN:
				r = '{4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11, 4'd12,
					4'd0, 4'd0, 4'd0, 4'd0, 4'd0};
			SC_MAJOR:
				r = '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11, 4'd12,
					4'd0, 4'd0, 4'd0, 4'd0, 4'd0};
			SC_MEL_MINOR:
				r = '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd9, 4'd10,
					4'd11, 4'd12, 4'd0, 4'd0, 4'd0};
			SC_MIXOLYDIAN:
				r = '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd10, 4'd12,
					4'd0, 4'd0, 4'd0, 4'd0, 4'd0};
			SC_PENTATONIC:
				r = '{4'd0, 4'd2, 4'd4, 4'd7, 4'd9, 4'd12, 4'd0, 4'd0,
					4'd0, 4'd0, 4'd0, 4'd0, 4'd0};
			SC_PHRYGIAN:
				r = '{4'd0, 4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12,
					4'd0, 4'd0, 4'd0, 4'd0, 4'd0};
			SC_TURKISH:
				r = '{4'd0, 4'd1, 4'd3, 4'd5, 4'd7, 4'd10, 4'd11, 4'd12,
					4'd0, 4'd0, 4'd0, 4'd0, 4'd0};
			default:
				r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [NOTE_W-1:0] scale_len(input logic [4:0] sc);
		logic [NOTE_W-1:0] n;
		case (sc)
			SC_BLUES:      n = 4'd7;
			SC_CHROMATIC:  n = 4'd13;
			SC_MEL_MINOR:  n = 4'd10;
			SC_PENTATONIC: n = 4'd6;
			default:       n = 4'd8;
		endcase
		return n;
	endfunction

	// bit i kept: entry i of an eight-note scale
	function automatic logic [7:0] sparse_mask(input logic [2:0] sp);
		logic [7:0] m;
		case (sp)
			SP_TRIAD:     m = 8'h15;
			SP_THIRD:     m = 8'h05;
			SP_FIFTH:     m = 8'h11;
			SP_ROOT_ONLY: m = 8'h01;
			default:      m = 8'hFF;
		endcase
		return m;
	endfunction

	// k semitones as a voltage, rounded to nearest, built at elaboration
	function automatic logic [NV_ENTRIES*NV_W-1:0] build_note_volts();
		logic [NV_ENTRIES*NV_W-1:0] t;
		t = '0;
		for (int k = 0; k < NV_ENTRIES; k++) begin
			t[k*NV_W +: NV_W] = NV_W'((k * ONE + 6) / 12);
		end
		return t;
	endfunction

	localparam logic [NV_ENTRIES*NV_W-1:0] NOTE_VOLTS = build_note_volts();

endpackage

// ===== sv/scale_pitch_quantizer.sv =====
// scale_pitch_quantizer: snaps a 1 V/octave pitch voltage to a scale note, or passes it through for scale none
// an accepted input request is captured in stage one and its result is registered in stage two, which drives m_*
// one request per cycle unless a stalled result on m_* holds the pipeline, set by the input and output registers
// the note search is a single pass through a combinational compare tree between the two registers
// reset: arst_n asynchronous, clears pipeline valids and restores the
// registers (root 0, scale chromatic, sparsity full); no clearing pass
`include "scale_pitch_quantizer_defines.svh"

module scale_pitch_quantizer (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [19:0] volts_in, [23:20] zero
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [19:0] volts_out, [27:20] semitone, [31:28] zero
	output logic        m_tuser,   // [0] passed_through
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int VW = spq_pkg::VOLT_W;
	localparam int SW = spq_pkg::SEMI_W;

	spq_pkg::cfg_t  cfg;
	spq_pkg::res_t  res;

	// stage one holds the captured request, stage two is the output register
	logic                  valid_s1;
	logic signed [VW-1:0]  volts_s1;
	logic                  valid_s2;
	spq_pkg::res_t         res_s2;
	logic                  adv_s2;
	logic                  load_s2;

	assign pready = 1'b1;

	spq_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// output register frees up when empty or when its result is taken
	assign adv_s2   = !valid_s2 || m_tready;
	assign load_s2  = valid_s1 && adv_s2;
	// stage one refills whenever it is empty or moving on
	assign s_tready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (adv_s2)   valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) volts_s1 <= s_tdata[VW-1:0];
		if (load_s2)              res_s2   <= res;
	end

	// quantiser logic between the two registers
	spq_quant u_quant (
		.volts (volts_s1),
		.cfg   (cfg),
		.res   (res)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(32-VW-SW){1'b0}}, res_s2.semitone, res_s2.volts_out};
	assign m_tuser  = res_s2.passed_through;

	// a pass-through result never carries a semitone number
	`SPQ_ASSERT_NOW(a_pass_semi_zero, m_tvalid && m_tuser, m_tdata[27:20] == 8'd0)
	// a request waiting behind a stalled result is kept, not dropped
	`SPQ_ASSERT_NEXT(a_s1_held, valid_s1 && valid_s2 && !m_tready, valid_s1 && valid_s2)
	// a request moving on always lands in the output register
	`SPQ_ASSERT_NEXT(a_s2_loaded, valid_s1 && (!valid_s2 || m_tready), m_tvalid)

endmodule

// ===== sv/spq_regs.sv =====
module spq_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output spq_pkg::cfg_t      cfg
);

	logic       wr_en;
	logic [1:0] reg_idx;
	logic [3:0] root_q;
	logic [4:0] scale_q;
	logic [2:0] sparse_q;

	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q   <= spq_pkg::RST_ROOT;
			scale_q  <= spq_pkg::RST_SCALE;
			sparse_q <= spq_pkg::RST_SPARSE;
		end else if (wr_en) begin
			unique case (reg_idx)
				spq_pkg::REG_ROOT:   root_q   <= pwdata[3:0];
				spq_pkg::REG_SCALE:  scale_q  <= pwdata[4:0];
				spq_pkg::REG_SPARSE: sparse_q <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			spq_pkg::REG_ROOT:   prdata = {28'd0, root_q};
			spq_pkg::REG_SCALE:  prdata = {27'd0, scale_q};
			spq_pkg::REG_SPARSE: prdata = {29'd0, sparse_q};
			default:             prdata = 32'd0;
		endcase
	end

	assign cfg.root_note    = root_q;
	assign cfg.scale_select = scale_q;
	assign cfg.sparsity     = sparse_q;

endmodule

// ===== sv/spq_quant.sv =====
module spq_quant (
	input  logic signed [spq_pkg::VOLT_W-1:0] volts,
	input  spq_pkg::cfg_t                     cfg,
	output spq_pkg::res_t                     res
);

	localparam int FB  = spq_pkg::FRAC_BITS;
	localparam int VW  = spq_pkg::VOLT_W;
	localparam int OW  = spq_pkg::OCT_W;
	localparam int DW  = spq_pkg::DIST_W;
	localparam int NW  = spq_pkg::NOTE_W;
	localparam int SW  = spq_pkg::SEMI_W;
	localparam int KW  = spq_pkg::KEY_W;
	localparam int NVW = spq_pkg::NV_W;
	localparam int LV  = spq_pkg::LEAVES;

	spq_pkg::row_t                  row;
	logic [NW-1:0]                  len;
	logic [7:0]                     mask8;
	logic [0:spq_pkg::MAX_NOTES-1]  keep;
	logic [OW-1:0]                  oct;
	logic [FB-1:0]                  frac;
	logic [DW-1:0]                  frac12;
	logic signed [DW:0]             diff;
	logic [DW-1:0]                  d0 [LV];
	logic [NW-1:0]                  n0 [LV];
	logic [DW-1:0]                  d1 [LV/2];
	logic [NW-1:0]                  n1 [LV/2];
	logic [DW-1:0]                  d2 [LV/4];
	logic [NW-1:0]                  n2 [LV/4];
	logic [DW-1:0]                  d3 [LV/8];
	logic [NW-1:0]                  n3 [LV/8];
	logic [NW-1:0]                  best;
	logic [KW-1:0]                  key;
	logic [NVW-1:0]                 nv;
	logic signed [VW+1:0]           sum;
	logic signed [SW:0]             oct_ext;
	logic signed [SW:0]             semi;

	assign oct    = volts[VW-1:FB];
	assign frac   = volts[FB-1:0];
	assign frac12 = ({{NW{1'b0}}, frac} << 3) + ({{NW{1'b0}}, frac} << 2);

	always_comb begin
		row   = spq_pkg::scale_row(cfg.scale_select);
		len   = spq_pkg::scale_len(cfg.scale_select);
		mask8 = (len == NW'(8)) ? spq_pkg::sparse_mask(cfg.sparsity) : 8'hFF;
		diff  = '0;
		for (int i = 0; i < spq_pkg::MAX_NOTES; i++) begin
			keep[i] = (NW'(i) < len);
			if (i < 8) keep[i] = keep[i] & mask8[3'(i)];
		end
		// leaves: distance in twelfths of a fraction unit, masked notes pushed out
		for (int i = 0; i < LV; i++) begin
			d0[i] = '1;
			n0[i] = '0;
			if (i < spq_pkg::MAX_NOTES) begin
				diff = $signed({1'b0, frac12}) - $signed({1'b0, row[i], {FB{1'b0}}});
				n0[i] = row[i];
				if (keep[i]) d0[i] = diff[DW] ? DW'(-diff) : diff[DW-1:0];
			end
		end
		// tree keeps the left leaf on a tie, so the earliest note wins
		for (int i = 0; i < LV/2; i++) begin
			if (d0[2*i+1] < d0[2*i]) begin
				d1[i] = d0[2*i+1]; n1[i] = n0[2*i+1];
			end else begin
				d1[i] = d0[2*i];   n1[i] = n0[2*i];
			end
		end
		for (int i = 0; i < LV/4; i++) begin
			if (d1[2*i+1] < d1[2*i]) begin
				d2[i] = d1[2*i+1]; n2[i] = n1[2*i+1];
			end else begin
				d2[i] = d1[2*i];   n2[i] = n1[2*i];
			end
		end
		for (int i = 0; i < LV/8; i++) begin
			if (d2[2*i+1] < d2[2*i]) begin
				d3[i] = d2[2*i+1]; n3[i] = n2[2*i+1];
			end else begin
				d3[i] = d2[2*i];   n3[i] = n2[2*i];
			end
		end
		best = (d3[1] < d3[0]) ? n3[1] : n3[0];
	end

	assign key     = KW'({1'b0, cfg.root_note} + {1'b0, best});
	assign nv      = spq_pkg::NOTE_VOLTS[key*NVW +: NVW];
	assign sum     = $signed({{2{oct[OW-1]}}, oct, {FB{1'b0}}})
		+ $signed({{(VW+2-NVW){1'b0}}, nv});
	assign oct_ext = $signed({{(SW+1-OW){oct[OW-1]}}, oct});
	assign semi    = (oct_ext <<< 3) + (oct_ext <<< 2) + $signed({{(SW+1-KW){1'b0}}, key});

	always_comb begin
		if (cfg.scale_select >= spq_pkg::SC_NONE) begin
			res.volts_out      = volts;
			res.semitone       = '0;
			res.passed_through = 1'b1;
		end else begin
			res.passed_through = 1'b0;
			res.semitone       = semi[SW-1:0];
			if (!sum[VW+1] && (sum[VW] || sum[VW-1]))
				res.volts_out = {1'b0, {(VW-1){1'b1}}};
			else if (sum[VW+1] && !(sum[VW] && sum[VW-1]))
				res.volts_out = {1'b1, {(VW-1){1'b0}}};
			else
				res.volts_out = sum[VW-1:0];
		end
	end

endmodule
